/* rtl/kwm_pkg.sv */
package kwm_pkg;

   localparam int MAX_SOURCES = 16;
   localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_POPPED   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic        command;
      logic [3:0]  source;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  popped_source;
      logic [63:0] popped_key;
   } rsp_type;

   // One heap slot.
   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  source;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      idx_type   rd_addr_a;
      idx_type   rd_addr_b;
   } ram_req_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // True when entry a leaves the heap before entry b.
   function automatic logic goes_first(entry_type a, entry_type b);
      logic result;
      if (a.key != b.key) begin
         result = (a.key < b.key);
      end else begin
         result = (a.source < b.source);
      end
      return result;
   endfunction

endpackage

/* rtl/kwm_heap_ram.sv */
module kwm_heap_ram
   import kwm_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output entry_type   rd_data_a,
   output entry_type   rd_data_b
);

   entry_type mem [MAX_SOURCES];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_a_ff <= mem[ram_req.rd_addr_a];
      rd_b_ff <= mem[ram_req.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/kwm_ctrl.sv */
module kwm_ctrl
   import kwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   input  logic        slot_free,
   output result_type  result,
   output ram_req_type ram_req,
   input  entry_type   rd_data_a,
   input  entry_type   rd_data_b
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_PLACE,
      S_POP,
      S_DOWN,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   cnt_type    pos_ff, pos_in;
   entry_type  move_ff, move_in;
   entry_type  res_ff, res_in;
   logic [1:0] status_ff, status_in;

   cnt_type          up_parent;
   cnt_type          up_grand;
   cnt_type          new_parent;
   logic [CNT_W:0]   child_l;
   logic [CNT_W:0]   child_r;
   logic [CNT_W:0]   child_sel;
   logic [CNT_W+1:0] next_l;
   logic             l_ok, r_ok;
   logic             a_before_move, b_before_move, b_before_a;
   logic             pick_l, pick_r;

   always_comb begin
      new_parent    = (count_ff - cnt_type'(1)) >> 1;
      up_parent     = (pos_ff - cnt_type'(1)) >> 1;
      up_grand      = (up_parent - cnt_type'(1)) >> 1;
      child_l       = {pos_ff, 1'b1};
      child_r       = child_l + (CNT_W+1)'(1);
      l_ok          = (child_l < {1'b0, count_ff});
      r_ok          = (child_r < {1'b0, count_ff});
      a_before_move = goes_first(rd_data_a, move_ff);
      b_before_move = goes_first(rd_data_b, move_ff);
      b_before_a    = goes_first(rd_data_b, rd_data_a);
      // Same order of tests as a textbook sift-down: left first, right against the winner.
      pick_l        = l_ok && a_before_move;
      pick_r        = r_ok && (pick_l ? b_before_a : b_before_move);
      child_sel     = pick_r ? child_r : child_l;
      next_l        = {child_sel, 1'b1};
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      move_in   = move_ff;
      res_in    = res_ff;
      status_in = status_ff;
      ram_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_data.command == CMD_INSERT) begin
                  if (count_ff >= cnt_type'(MAX_SOURCES)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     status_in = STATUS_INSERTED;
                     count_in  = count_ff + cnt_type'(1);
                     move_in   = '{key: req_data.key, source: req_data.source};
                     pos_in    = count_ff;
                     if (count_ff == '0) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = '0;
                        ram_req.wr_data = '{key: req_data.key, source: req_data.source};
                        state_in        = S_FINISH;
                     end else begin
                        ram_req.rd_addr_a = new_parent[IDX_W-1:0];
                        state_in          = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     status_in         = STATUS_POPPED;
                     ram_req.rd_addr_a = '0;
                     ram_req.rd_addr_b = idx_type'(count_ff - cnt_type'(1));
                     count_in          = count_ff - cnt_type'(1);
                     state_in          = S_POP;
                  end
               end
            end
         end
         S_UP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff[IDX_W-1:0];
            if (goes_first(move_ff, rd_data_a)) begin
               // Parent moves down into the hole; the hole climbs one level.
               ram_req.wr_data = rd_data_a;
               pos_in          = up_parent;
               if (up_parent == '0) begin
                  state_in = S_PLACE;
               end else begin
                  ram_req.rd_addr_a = up_grand[IDX_W-1:0];
               end
            end else begin
               ram_req.wr_data = move_ff;
               state_in        = S_FINISH;
            end
         end
         S_PLACE: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff[IDX_W-1:0];
            ram_req.wr_data = move_ff;
            state_in        = S_FINISH;
         end
         S_POP: begin
            res_in  = rd_data_a;
            move_in = rd_data_b;
            if (count_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               pos_in            = '0;
               ram_req.rd_addr_a = idx_type'(1);
               ram_req.rd_addr_b = idx_type'(2);
               state_in          = S_DOWN;
            end
         end
         S_DOWN: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff[IDX_W-1:0];
            if (pick_l || pick_r) begin
               // Smaller child moves up; the hole sinks into its slot.
               ram_req.wr_data   = pick_r ? rd_data_b : rd_data_a;
               pos_in            = child_sel[CNT_W-1:0];
               ram_req.rd_addr_a = next_l[IDX_W-1:0];
               ram_req.rd_addr_b = idx_type'(next_l + (CNT_W+2)'(1));
            end else begin
               ram_req.wr_data = move_ff;
               state_in        = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      move_ff   <= move_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign req_stall                 = (state_ff != S_IDLE);
   assign result.valid              = (state_ff == S_FINISH) && slot_free;
   assign result.data.status        = status_ff;
   assign result.data.popped_source = res_ff.source;
   assign result.data.popped_key    = res_ff.key;

endmodule

/* rtl/k_way_merge_min_heap_top.sv */
// Path to the result: an insert climbs one level per step (up to 4 levels), and a pop refills
// the root and sinks it one level per step (up to 3 levels); a first or rejected insert, an empty
// pop and a pop of the last entry skip the sift. The result waits for a free output slot.
// Throughput: one word at a time, and no new request is taken until the result is out; one sift
// level per cycle, set by the single write port and the registered reads of the memory.
// Reset (synchronous, active high) empties the heap at once; no clearing pass is needed.
module k_way_merge_min_heap_top
   import kwm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ram_req_type ram_req;
   entry_type   rd_data_a;
   entry_type   rd_data_b;
   result_type  result;
   logic        slot_free;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   kwm_heap_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .slot_free (slot_free),
      .result    (result),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // The output word may be replaced in the cycle it is taken.
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_data_ff <= result.data;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
